@@ hdl/vn_pkg.sv @@
// vn_pkg: shared constants for the vector normalizer.
// No dependencies; used by vn_res_if, vector_normalize and the testbench.
package vn_pkg;
	localparam int unsigned MAX_COMPONENTS_DEF = 4;
	localparam int unsigned COMPONENT_BITS_DEF = 16;
	localparam int unsigned LANES              = 4;
	localparam int unsigned MIN_COMPONENTS     = 2;
	localparam int unsigned SIZE_BITS          = 3;
	localparam logic [SIZE_BITS-1:0] VECTOR_SIZE_RESET = 3'd3;
	localparam int unsigned OUT_BITS           = 16;
	localparam int unsigned LEN_BITS           = 17;
	localparam int unsigned QUOT_BITS          = 15;
	localparam logic [LEN_BITS-1:0] LEN_MAX    = '1;
endpackage

@@ hdl/vn_if.sv @@
// vn_vec_if / vn_res_if: request and result channels of the vector normalizer.
// vn_res_if depends on vn_pkg for field widths; vn_vec_if takes its width from W.
interface vn_vec_if #(parameter int unsigned W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] x_in;
	logic [W-1:0] y_in;
	logic [W-1:0] z_in;
	logic [W-1:0] w_in;
	modport source (output valid, x_in, y_in, z_in, w_in, input ready);
	modport sink (input valid, x_in, y_in, z_in, w_in, output ready);
endinterface

interface vn_res_if;
	import vn_pkg::*;
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] x_out;
	logic [OUT_BITS-1:0] y_out;
	logic [OUT_BITS-1:0] z_out;
	logic [OUT_BITS-1:0] w_out;
	logic [LEN_BITS-1:0] length;
	logic                zero_vector;
	modport source (output valid, x_out, y_out, z_out, w_out, length, zero_vector,
		input ready);
	modport sink (input valid, x_out, y_out, z_out, w_out, length, zero_vector,
		output ready);
endinterface

@@ hdl/vector_normalize.sv @@
// vector_normalize: pipelined Euclidean normalizer, Q8.8 in, Q1.14 unit vector out.
// Depends on vn_pkg and the channel interfaces in vn_if.sv.
//
// Usage:
//   vec carries one vector request (x_in..w_in, signed) per accepted
//   valid/ready beat; res returns the unit vector, the floor-sqrt length and
//   a zero_vector flag, one result per request, in order.
//   vector_size (write enable + data) selects 2..4 components; values below
//   2 act as 2, above MAX_COMPONENTS as MAX_COMPONENTS. Unused outputs are 0.
// Throughput: one request per cycle while res is taken.
// Pipeline: square, sum, one stage per root bit (COMPONENT_BITS + 1),
//   one per quotient bit (15), and the output register.
// Stall: when res is held off, the whole pipeline freezes and vec.ready
//   drops; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and sets vector_size to 3.
module vector_normalize #(
	parameter int unsigned MAX_COMPONENTS = vn_pkg::MAX_COMPONENTS_DEF,
	parameter int unsigned COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vector_size_we,
	input  logic [vn_pkg::SIZE_BITS-1:0] vector_size_wdata,
	vn_vec_if.sink                      vec,
	vn_res_if.source                    res
);
	import vn_pkg::*;

	localparam int unsigned C   = COMPONENT_BITS;
	localparam int unsigned RW  = C + 1;          // root bits
	localparam int unsigned SW  = 2 * RW;         // radicand bits
	localparam int unsigned RMW = RW + 3;         // root remainder bits
	localparam int unsigned DW  = RW + 1;         // divider remainder bits
	localparam int unsigned QB  = QUOT_BITS;
	localparam int unsigned CW  = (RW > LEN_BITS) ? RW : LEN_BITS;

	logic [SIZE_BITS-1:0] vector_size_q;
	logic                 adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_size_q <= VECTOR_SIZE_RESET;
		end else if (vector_size_we) begin
			vector_size_q <= vector_size_wdata;
		end
	end

	assign adv       = !res.valid || res.ready;
	assign vec.ready = adv;

	// ---------------- input: magnitudes and squares
	logic [SIZE_BITS-1:0] used;
	logic [C-1:0]         comp_in [LANES];
	logic [C-1:0]         mag_n [LANES];
	logic                 neg_n [LANES];

	assign comp_in[0] = vec.x_in;
	assign comp_in[1] = vec.y_in;
	assign comp_in[2] = vec.z_in;
	assign comp_in[3] = vec.w_in;

	always_comb begin
		if (vector_size_q < SIZE_BITS'(MIN_COMPONENTS)) begin
			used = SIZE_BITS'(MIN_COMPONENTS);
		end else if (vector_size_q > SIZE_BITS'(MAX_COMPONENTS)) begin
			used = SIZE_BITS'(MAX_COMPONENTS);
		end else begin
			used = vector_size_q;
		end
		for (int i = 0; i < LANES; i++) begin
			// unused lanes become zero and fall out of every later step
			if (used > SIZE_BITS'(i)) begin
				neg_n[i] = comp_in[i][C-1];
				mag_n[i] = comp_in[i][C-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
			end else begin
				neg_n[i] = 1'b0;
				mag_n[i] = '0;
			end
		end
	end

	logic           v_s1;
	logic [C-1:0]   mag_s1 [LANES];
	logic           neg_s1 [LANES];
	logic [2*C-1:0] sq_s1 [LANES];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				mag_s1[i] <= mag_n[i];
				neg_s1[i] <= neg_n[i];
				sq_s1[i]  <= mag_n[i] * mag_n[i];
			end
		end
	end

	// ---------------- sum of squares
	logic          v_s2;
	logic [C-1:0]  mag_s2 [LANES];
	logic          neg_s2 [LANES];
	logic [SW-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sum_s2 <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]) + SW'(sq_s1[3]);
		end
	end

	// ---------------- square root, one root bit per stage
	logic           v_s3   [RW];
	logic [SW-1:0]  rad_s3 [RW];
	logic [RMW-1:0] rem_s3 [RW];
	logic [RW-1:0]  root_s3 [RW];
	logic [C-1:0]   mag_s3 [RW][LANES];
	logic           neg_s3 [RW][LANES];

	logic [SW-1:0]  rad_i  [RW];
	logic [RMW-1:0] rem_i  [RW];
	logic [RW-1:0]  root_i [RW];
	logic [C-1:0]   mag_i  [RW][LANES];
	logic           neg_i  [RW][LANES];
	logic           v_i    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_rt_in
		if (k == 0) begin : g_first
			assign v_i[k]    = v_s2;
			assign rad_i[k]  = sum_s2;
			assign rem_i[k]  = '0;
			assign root_i[k] = '0;
			assign mag_i[k]  = mag_s2;
			assign neg_i[k]  = neg_s2;
		end else begin : g_next
			assign v_i[k]    = v_s3[k-1];
			assign rad_i[k]  = rad_s3[k-1];
			assign rem_i[k]  = rem_s3[k-1];
			assign root_i[k] = root_s3[k-1];
			assign mag_i[k]  = mag_s3[k-1];
			assign neg_i[k]  = neg_s3[k-1];
		end
	end

	logic [SW-1:0]  rad_n  [RW];
	logic [RMW-1:0] rem_n  [RW];
	logic [RW-1:0]  root_n [RW];

	always_comb begin
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		for (int k = 0; k < RW; k++) begin
			cur   = {rem_i[k][RMW-3:0], rad_i[k][SW-1 -: 2]};
			trial = RMW'({root_i[k], 2'b01});
			rad_n[k] = rad_i[k] << 2;
			if (cur >= trial) begin
				rem_n[k]  = cur - trial;
				root_n[k] = {root_i[k][RW-2:0], 1'b1};
			end else begin
				rem_n[k]  = cur;
				root_n[k] = {root_i[k][RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= rad_n;
			rem_s3  <= rem_n;
			root_s3 <= root_n;
			mag_s3  <= mag_i;
			neg_s3  <= neg_i;
		end
	end

	// ---------------- division, one quotient bit per stage
	logic          v_s4   [QB];
	logic [RW-1:0] len_s4 [QB];
	logic [DW-1:0] r_s4   [QB][LANES];
	logic [QB-1:0] q_s4   [QB][LANES];
	logic          neg_s4 [QB][LANES];

	logic          dv_i   [QB];
	logic [RW-1:0] len_i  [QB];
	logic [DW-1:0] r_i    [QB][LANES];
	logic [QB-1:0] q_i    [QB][LANES];
	logic          dneg_i [QB][LANES];

	for (genvar j = 0; j < QB; j++) begin : g_dv_in
		if (j == 0) begin : g_first
			assign dv_i[j]   = v_s3[RW-1];
			assign len_i[j]  = root_s3[RW-1];
			assign dneg_i[j] = neg_s3[RW-1];
			for (genvar c = 0; c < LANES; c++) begin : g_lane
				assign r_i[j][c] = DW'(mag_s3[RW-1][c]);
				assign q_i[j][c] = '0;
			end
		end else begin : g_next
			assign dv_i[j]   = v_s4[j-1];
			assign len_i[j]  = len_s4[j-1];
			assign dneg_i[j] = neg_s4[j-1];
			for (genvar c = 0; c < LANES; c++) begin : g_lane
				assign r_i[j][c] = {r_s4[j-1][c][DW-2:0], 1'b0};
				assign q_i[j][c] = q_s4[j-1][c];
			end
		end
	end

	logic [DW-1:0] r_n [QB][LANES];
	logic [QB-1:0] q_n [QB][LANES];

	always_comb begin
		logic          ge;
		logic [DW-1:0] d;
		for (int j = 0; j < QB; j++) begin
			d = DW'(len_i[j]);
			for (int c = 0; c < LANES; c++) begin
				ge = r_i[j][c] >= d;
				r_n[j][c] = ge ? (r_i[j][c] - d) : r_i[j][c];
				q_n[j][c] = {q_i[j][c][QB-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s4 <= len_i;
			neg_s4 <= dneg_i;
			r_s4   <= r_n;
			q_s4   <= q_n;
		end
	end

	// ---------------- output register
	logic                zero_n;
	logic [CW-1:0]       len_w;
	logic [LEN_BITS-1:0] len_o;
	logic [OUT_BITS-1:0] comp_o [LANES];

	always_comb begin
		zero_n = (len_s4[QB-1] == '0);
		len_w  = CW'(len_s4[QB-1]);
		len_o  = (len_w > CW'(LEN_MAX)) ? LEN_MAX : len_w[LEN_BITS-1:0];
		for (int c = 0; c < LANES; c++) begin
			if (zero_n) begin
				comp_o[c] = '0;
			end else if (neg_s4[QB-1][c]) begin
				comp_o[c] = -OUT_BITS'(q_s4[QB-1][c]);
			end else begin
				comp_o[c] = OUT_BITS'(q_s4[QB-1][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.x_out       <= comp_o[0];
			res.y_out       <= comp_o[1];
			res.z_out       <= comp_o[2];
			res.w_out       <= comp_o[3];
			res.length      <= len_o;
			res.zero_vector <= zero_n;
		end
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= '{default: 1'b0};
			v_s4      <= '{default: 1'b0};
			res.valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= vec.valid;
			v_s2      <= v_s1;
			v_s3      <= v_i;
			v_s4      <= dv_i;
			res.valid <= v_s4[QB-1];
		end
	end
endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for vector_normalize (Euclidean unit vector).
// Depends on vn_pkg, vn_if.sv and the vector_normalize RTL; predicts each result
// from the request and compares it field by field at the result channel.
`timescale 1ns / 1ps

module testbench;
	import vn_pkg::*;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] w;
	} vec_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] w;
		logic [LEN_BITS-1:0] len;
		logic zero;
	} unit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic size_we = 1'b0;
	logic [SIZE_BITS-1:0] size_wdata = '0;

	vn_vec_if #(.W(16)) vec ();
	vn_res_if res ();

	vector_normalize uut (
		.clk(clk), .arst_n(arst_n),
		.vector_size_we(size_we), .vector_size_wdata(size_wdata),
		.vec(vec.sink), .res(res.source)
	);

	vec_t pending_q[$];
	unit_t unit_q[$];
	logic [SIZE_BITS-1:0] cur_size;
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	// request taken at the last rising edge; ready may have moved since
	bit vec_fire = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] isqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic unit_t normalize(vec_t v, logic [SIZE_BITS-1:0] sz);
		logic [15:0] c[4];
		logic [16:0] mag[4];
		logic [63:0] sum;
		logic [31:0] len;
		logic [31:0] q;
		logic [15:0] o[4];
		int used;
		unit_t u;
		c[0] = v.x; c[1] = v.y; c[2] = v.z; c[3] = v.w;
		used = (sz < MIN_COMPONENTS) ? MIN_COMPONENTS : (sz > 4 ? 4 : sz);
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = c[i][15] ? (17'h10000 - {1'b0, c[i]}) : {1'b0, c[i]};
			if (i < used) sum = sum + mag[i] * mag[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 4; i++) begin
			o[i] = 0;
			if (i < used && len != 0) begin
				q = ({15'd0, mag[i]} << 14) / len;
				o[i] = c[i][15] ? (16'd0 - q[15:0]) : q[15:0];
			end
		end
		u.x = o[0]; u.y = o[1]; u.z = o[2]; u.w = o[3];
		u.len = len[LEN_BITS-1:0];
		u.zero = (len == 0);
		return u;
	endfunction

	// driver: one request per cycle unless idling; valid held until accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (!vec.valid || vec_fire) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					vec.valid <= 1'b1;
					{vec.x_in, vec.y_in, vec.z_in, vec.w_in} <= pending_q.pop_front();
				end else begin
					vec.valid <= 1'b0;
				end
			end
			res.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		unit_t got;
		unit_t exp_u;
		if (arst_n) begin
			vec_fire = vec.valid && vec.ready;
			if (vec.valid && vec.ready)
				unit_q.push_back(normalize({vec.x_in, vec.y_in, vec.z_in, vec.w_in},
					cur_size));
			if (res.valid && res.ready) begin
				got = {res.x_out, res.y_out, res.z_out, res.w_out, res.length,
					res.zero_vector};
				if (unit_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					exp_u = unit_q.pop_front();
					if (got !== exp_u) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp x%h y%h z%h w%h len%h z%b got x%h y%h z%h w%h len%h z%b",
								exp_u.x, exp_u.y, exp_u.z, exp_u.w, exp_u.len, exp_u.zero,
								got.x, got.y, got.z, got.w, got.len, got.zero);
					end
				end
			end
		end
	end

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (pending_q.size() != 0 || unit_q.size() != 0 || vec.valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_size(logic [SIZE_BITS-1:0] s);
		@(negedge clk);
		size_we <= 1'b1;
		size_wdata <= s;
		@(negedge clk);
		size_we <= 1'b0;
		cur_size = s;
	endtask

	task automatic load_random(int n);
		vec_t v;
		repeat (n) begin
			v = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			if ($urandom_range(15) == 0) v = '0;
			pending_q.push_back(v);
		end
	endtask

	initial begin
		logic [SIZE_BITS-1:0] sizes[8];
		vec.valid = 1'b0;
		vec.x_in = '0; vec.y_in = '0; vec.z_in = '0; vec.w_in = '0;
		res.ready = 1'b0;
		cur_size = VECTOR_SIZE_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: extremes, zero vector, unused lanes nonzero at reset size
		pending_q.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
		pending_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		pending_q.push_back('0);
		pending_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h1234});
		pending_q.push_back({16'h0001, 16'h0000, 16'h0000, 16'h0000});
		pending_q.push_back({16'hFFFF, 16'h0001, 16'h0000, 16'h0000});
		pending_q.push_back({16'h0300, 16'h0400, 16'h0000, 16'hFFFF});
		pending_q.push_back({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
		drain();
		sizes = '{3'd0, 3'd7, 3'd2, 3'd4, 3'd1, 3'd5, 3'd3, 3'd6};
		foreach (sizes[i]) begin
			set_size(sizes[i]);
			pending_q.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
			pending_q.push_back({16'h0000, 16'h0000, 16'h4000, 16'h8000});
			pending_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h8000});
			if (i == 0) begin
				send_idle = 26; recv_idle = 76;
			end else if (i == 3) begin
				send_idle = 76; recv_idle = 26;
			end else if (i == 6) begin
				send_idle = 0; recv_idle = 0;
			end
			load_random(88);
			drain();
		end
		if (errors == 0) begin
			$display("** vector_normalize: PASSED **");
		end else begin
			$display("** vector_normalize: FAILED **");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("** vector_normalize: FAILED **");
		$finish;
	end
endmodule

@@ vector_normalize.f @@
hdl/vn_pkg.sv
hdl/vn_if.sv
hdl/vector_normalize.sv
bench/testbench.sv
